### rtl/core/iwr_pkg.sv
// Package for the instruction window: field widths, opcodes, item and result
// types, and the command/status structs between controller and datapath.
// No dependencies.
package iwr_pkg;

	localparam int unsigned IWR_DEPTH_DEFAULT = 128;

	localparam int unsigned ADDR_W     = 48;
	localparam int unsigned OP_W       = 2;
	localparam int unsigned RW_W       = 4;
	localparam int unsigned RCNT_W     = 4;
	localparam int unsigned OCC_W      = 8;
	localparam int unsigned MAX_RETIRE = 8;
	localparam logic [RW_W-1:0] RW_RESET = 4'd4;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_MARK   = 2'd1;
	localparam logic [OP_W-1:0] OP_RETIRE = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] match_mask;
		logic              ready_on_insert;
	} iwr_item_t;

	typedef struct packed {
		logic              accepted;
		logic [RCNT_W-1:0] retired_count;
		logic [OCC_W-1:0]  occupancy;
		logic              is_full;
		logic              empty_flag;
	} iwr_result_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              ready;
	} iwr_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic latch_item;
		logic exec_insert;
		logic mark_init;
		logic mark_issue;
		logic ret_init;
		logic ret_issue;
		logic ret_pop;
		logic result_load;
	} iwr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            empty;
		logic            sweep_last;
		logic            head_ready;
		logic            ret_last;
		logic            ret_none;
		logic            out_free;
	} iwr_sts_t;

endpackage

### rtl/core/iwr_if.sv
// Handshake channels of the instruction window: item in, result out.
// Depends on iwr_pkg.
interface iwr_item_if import iwr_pkg::*;;
	logic      valid;
	logic      ready;
	iwr_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface iwr_result_if import iwr_pkg::*;;
	logic        valid;
	logic        ready;
	iwr_result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/iwr_ctrl.sv
// Controller state machine of the instruction window.
// Depends on iwr_pkg; drives iwr_dp through iwr_cmd_t, reads iwr_sts_t.
module iwr_ctrl import iwr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  iwr_sts_t sts,
	output iwr_cmd_t cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_EXEC     = 3'd1;
	localparam logic [2:0] S_MARK     = 3'd2;
	localparam logic [2:0] S_MARK_END = 3'd3;
	localparam logic [2:0] S_RET_RD   = 3'd4;
	localparam logic [2:0] S_RET_CHK  = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.latch_item = 1'b1;
					state_d        = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (sts.op)
					OP_INSERT: begin
						cmd.exec_insert = 1'b1;
						state_d         = S_DONE;
					end
					OP_MARK: begin
						if (sts.empty) begin
							state_d = S_DONE;
						end else begin
							cmd.mark_init = 1'b1;
							state_d       = S_MARK;
						end
					end
					OP_RETIRE: begin
						cmd.ret_init = 1'b1;
						state_d      = sts.ret_none ? S_DONE : S_RET_RD;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_MARK: begin
				cmd.mark_issue = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_MARK_END;
				end
			end
			// last compare and write-back happen in this cycle
			S_MARK_END: state_d = S_DONE;
			S_RET_RD: begin
				cmd.ret_issue = 1'b1;
				state_d       = S_RET_CHK;
			end
			S_RET_CHK: begin
				if (sts.head_ready) begin
					cmd.ret_pop = 1'b1;
					state_d     = sts.ret_last ? S_DONE : S_RET_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second item taken while one is in flight");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> sts.out_free && state_q == S_DONE)
		else $error("result loaded over a waiting result");

	a_pop_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ret_pop |-> $past(cmd.ret_issue))
		else $error("retire pop without a fresh read");

endmodule

### rtl/core/iwr_dp.sv
// Datapath of the instruction window: entry memory, pointers, count,
// mark-ready sweep, retire counter, retire-width register, result register.
// Depends on iwr_pkg; commanded by iwr_ctrl.
module iwr_dp import iwr_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = IWR_DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  iwr_item_t         item,
	input  logic              cfg_we,
	input  logic [RW_W-1:0]   cfg_wdata,
	input  iwr_cmd_t          cmd,
	output iwr_sts_t          sts,
	output iwr_result_t       result,
	output logic              result_valid,
	input  logic              result_ready
);

	localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
	localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_DEPTH);

	iwr_entry_t mem [WINDOW_DEPTH];

	iwr_item_t         item_q;
	logic [RW_W-1:0]   rw_q;
	logic [IDX_W-1:0]  oldest_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  sweep_slot_q;
	logic [CNT_W-1:0]  sweep_cnt_q;
	logic [RCNT_W-1:0] ret_cnt_q;
	logic              accepted_q;
	iwr_entry_t        rd_q;
	logic              rd_valid_s1;
	logic [IDX_W-1:0]  slot_s1;
	iwr_result_t       res_q;
	logic              res_valid_q;

	logic              full;
	logic              insert_do;
	logic              match;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	iwr_entry_t        wr_data;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_idx;
	logic [RW_W-1:0]   limit;

	assign full      = (count_q == FULL_CNT);
	assign insert_do = cmd.exec_insert && !full;
	assign limit     = (rw_q > RW_W'(MAX_RETIRE)) ? RW_W'(MAX_RETIRE) : rw_q;

	// mark-ready compare on the registered read data
	assign match = ((rd_q.address & item_q.match_mask) ==
		(item_q.address & item_q.match_mask));

	assign wr_en   = insert_do || (rd_valid_s1 && match);
	assign wr_idx  = insert_do ? head_q : slot_s1;
	assign wr_data = insert_do
		? iwr_entry_t'{address: item_q.address, ready: item_q.ready_on_insert}
		: iwr_entry_t'{address: rd_q.address, ready: 1'b1};

	assign rd_en  = cmd.mark_issue || cmd.ret_issue;
	assign rd_idx = cmd.mark_issue ? sweep_slot_q : oldest_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			item_q <= item;
		end
		slot_s1 <= sweep_slot_q;
		if (cmd.mark_init) begin
			sweep_slot_q <= oldest_q;
			sweep_cnt_q  <= '0;
		end else if (cmd.mark_issue) begin
			sweep_slot_q <= (sweep_slot_q == LAST_IDX) ? '0 : sweep_slot_q + 1'b1;
			sweep_cnt_q  <= sweep_cnt_q + 1'b1;
		end
		if (cmd.latch_item) begin
			accepted_q <= 1'b1;
		end else if (cmd.exec_insert && full) begin
			accepted_q <= 1'b0;
		end
		if (cmd.latch_item) begin
			ret_cnt_q <= '0;
		end else if (cmd.ret_pop) begin
			ret_cnt_q <= ret_cnt_q + 1'b1;
		end
		if (cmd.result_load) begin
			res_q.accepted      <= accepted_q;
			res_q.retired_count <= ret_cnt_q;
			res_q.occupancy     <= OCC_W'(count_q);
			res_q.is_full       <= full;
			res_q.empty_flag    <= (count_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rw_q        <= RW_RESET;
			oldest_q    <= '0;
			head_q      <= '0;
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rw_q <= cfg_wdata;
			end
			rd_valid_s1 <= cmd.mark_issue;
			if (insert_do) begin
				head_q  <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
				count_q <= count_q + 1'b1;
			end else if (cmd.ret_pop) begin
				oldest_q <= (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;
				count_q  <= count_q - 1'b1;
			end
			if (cmd.result_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign sts.op         = item_q.opcode;
	assign sts.empty      = (count_q == '0);
	assign sts.sweep_last = (sweep_cnt_q == count_q - CNT_W'(1));
	assign sts.head_ready = rd_q.ready;
	assign sts.ret_last   = ((ret_cnt_q + RCNT_W'(1)) == limit) || (count_q == CNT_W'(1));
	assign sts.ret_none   = (limit == '0) || (count_q == '0);
	assign sts.out_free   = !res_valid_q || result_ready;

	assign result       = res_q;
	assign result_valid = res_valid_q;

	logic [CNT_W:0] head_sum;
	assign head_sum = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("occupancy beyond window depth");

	a_head_track: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W + 1)'(head_q) == ((head_sum >= (CNT_W + 1)'(WINDOW_DEPTH))
			? head_sum - (CNT_W + 1)'(WINDOW_DEPTH) : head_sum))
		else $error("head pointer out of step with oldest slot and count");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ret_pop |-> count_q != '0 && ret_cnt_q < limit)
		else $error("retire pop beyond occupancy or width");

endmodule

### rtl/core/instruction_window_retire.sv
// Top level of the instruction window with in-order retirement.
// Depends on iwr_pkg, iwr_if (channels), iwr_ctrl and iwr_dp.
//
// Use: items arrive on item_in (valid/ready); each gives exactly one result
// on result_out (valid/ready). Opcodes: insert at the head, mark matching
// entries ready, retire from the oldest slot; any other code is a no-op.
// cfg_we/cfg_wdata write the retire width (reset 4, capped at 8); write it
// only while the block is idle.
//
// One item at a time. Insert, no-op, mark on an empty window, and retire on an
// empty window or at width 0 go straight to the result. Mark-ready sweeps the
// occupied entries from the oldest slot with one memory read per entry; the
// compare and write-back of each entry happen in the cycle after its read.
// Retire reads the oldest entry and pops it if ready, then reads the next,
// stopping at a not-ready entry, at the retire width or at an empty window.
// The entry memory has a single read and a single write port: the mark sweep
// and the retire walk each touch one entry per read.
// item_in.ready rises on the same edge as result_out.valid, so the next item
// is taken at the earliest in the first cycle in which result_out.valid is high.
// Reset: pointers and count clear, retire width returns to 4, no result
// pending; entry memory is not cleared (only occupied entries are read).
// Stall: the result register holds its item until taken; the next item is
// accepted meanwhile and its own result waits in the controller's final
// state until the register is free.
module instruction_window_retire import iwr_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = IWR_DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	iwr_item_if.sink          item_in,
	iwr_result_if.source      result_out,
	input  logic              cfg_we,
	input  logic [RW_W-1:0]   cfg_wdata
);

	iwr_cmd_t cmd;
	iwr_sts_t sts;

	// sequencing: accept, execute, sweep or walk, deliver
	iwr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_in.valid),
		.item_ready (item_in.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// storage, pointers and the result register
	iwr_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_in.payload),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result_out.payload),
		.result_valid (result_out.valid),
		.result_ready (result_out.ready)
	);

endmodule
